// ----- rtl/core/bmt_pkg.sv -----
// Shared types and codes for the bounded multiset table.
package bmt_pkg;

	localparam logic [2:0] KIND_INSERT      = 3'd0;
	localparam logic [2:0] KIND_ERASE_FIRST = 3'd1;
	localparam logic [2:0] KIND_ERASE_ALL   = 3'd2;
	localparam logic [2:0] KIND_COUNT       = 3'd3;
	localparam logic [2:0] KIND_READ        = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] item;
		logic [5:0]  position;
	} op_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  answer;
		logic [31:0] read_value;
		logic [6:0]  total_entries;
		logic [6:0]  distinct_entries;
	} op_res_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic rd_issue;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic scan_done;
	} dp_sts_t;

endpackage

// ----- rtl/core/bounded_multiset_table_top.sv -----
// Bounded multiset table: top level joining sequencer and datapath.
// Insert, erase first, erase all and count scan the n live entries through one
// registered memory read port, then finish registers the result. Read at
// position, insert on a full store, any op on an empty store and unused kinds skip
// the scan. Next item is accepted once busy drops. done is high for one cycle
// only; response holds until the next result. Reset empties the table at once.
module bounded_multiset_table_top
	import bmt_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  op_in_t  request,
	output logic    done,
	output op_res_t response
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	bmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (request.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bmt_dp #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cmd      (cmd),
		.sts      (sts),
		.done     (done),
		.response (response)
	);

endmodule

// ----- rtl/core/bmt_ctrl.sv -----
// Operation sequencer for the bounded multiset table.
module bmt_ctrl
	import bmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic [2:0] kind,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd,
	output logic     busy
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_FINISH} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						case (kind)
							KIND_INSERT: state_q <= (sts.full || sts.empty) ? S_FINISH : S_SCAN;
							KIND_ERASE_FIRST, KIND_ERASE_ALL, KIND_COUNT:
								state_q <= sts.empty ? S_FINISH : S_SCAN;
							KIND_READ: state_q <= S_READ;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_SCAN: begin
					if (sts.scan_done)
						state_q <= S_FINISH;
				end
				S_READ: state_q <= S_FINISH;
				S_FINISH: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy         = busy_q;
	assign cmd.load     = start && !busy_q;
	assign cmd.scan     = (state_q == S_SCAN);
	assign cmd.rd_issue = (state_q == S_READ);
	assign cmd.finish   = (state_q == S_FINISH);

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE)) else $error("busy out of step with state");

	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy_q) else $error("still busy after finish");

	a_load_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy_q) else $error("not busy after an item was taken");

endmodule

// ----- rtl/core/bmt_dp.sv -----
// Entry store, scan/compaction datapath and result register.
module bmt_dp
	import bmt_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  op_in_t   request,
	input  ctl_cmd_t cmd,
	output dp_sts_t  sts,
	output logic     done,
	output op_res_t  response
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int VW = VALUE_WIDTH;
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);
	localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);

	logic [VW-1:0] mem [DEPTH];

	logic [2:0]    kind_q;
	logic [VW-1:0] val_q;
	logic [5:0]    pos_q;
	logic [CW-1:0] total_q, distinct_q;
	logic [CW-1:0] issue_q, keep_q, match_q, first_pos_q;
	logic          found_q;
	logic          rvld_s1;
	logic [CW-1:0] rdidx_s1;
	logic [VW-1:0] rdata_s1;
	logic          done_q;
	op_res_t       res_q;

	logic [VW+31:0] item_x;
	logic [VW-1:0]  item_v;
	logic [AW+5:0]  pos_a;
	logic [CW+5:0]  pos_x, tot_x;
	logic           in_range;
	logic [AW-1:0]  raddr, waddr;
	logic [VW-1:0]  wdata;
	logic           we;
	logic           hit, skip, is_erase;
	logic           issuing;

	logic [1:0]     st_n;
	logic [CW-1:0]  ans_n, total_n, distinct_n;
	logic [VW+31:0] rd_x;
	logic [31:0]    rd_n;
	logic [CW+6:0]  ans_x, tot7_x, dis7_x;

	assign item_x   = {{VW{1'b0}}, request.item};
	assign item_v   = item_x[VW-1:0];
	assign pos_a    = {{AW{1'b0}}, pos_q};
	assign pos_x    = {{CW{1'b0}}, pos_q};
	assign tot_x    = {6'b0, total_q};
	assign in_range = pos_x < tot_x;

	assign issuing  = cmd.scan && (issue_q != total_q);
	assign raddr    = cmd.rd_issue ? pos_a[AW-1:0] : issue_q[AW-1:0];
	assign is_erase = (kind_q == KIND_ERASE_FIRST) || (kind_q == KIND_ERASE_ALL);
	assign hit      = rvld_s1 && (rdata_s1 == val_q);
	assign skip     = (kind_q == KIND_ERASE_ALL) ? hit : (hit && !found_q);

	always_comb begin
		we    = 1'b0;
		waddr = keep_q[AW-1:0];
		wdata = rdata_s1;
		if (cmd.finish && kind_q == KIND_INSERT && total_q != CNT_DEPTH) begin
			we    = 1'b1;
			waddr = total_q[AW-1:0];
			wdata = val_q;
		end else if (rvld_s1 && is_erase && !skip) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= request.kind;
			val_q  <= item_v;
			pos_q  <= request.position;
		end
		if (issuing)
			rdidx_s1 <= issue_q;
		if (rvld_s1 && hit && !found_q)
			first_pos_q <= rdidx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			keep_q  <= '0;
			match_q <= '0;
			found_q <= 1'b0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= issuing;
			if (cmd.load) begin
				issue_q <= '0;
				keep_q  <= '0;
				match_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (issuing)
					issue_q <= issue_q + CNT_ONE;
				if (rvld_s1) begin
					if (hit) begin
						match_q <= match_q + CNT_ONE;
						found_q <= 1'b1;
					end
					if (!skip)
						keep_q <= keep_q + CNT_ONE;
				end
			end
		end
	end

	assign sts.empty     = (total_q == '0);
	assign sts.full      = (total_q == CNT_DEPTH);
	assign sts.scan_done = (issue_q == total_q) && !rvld_s1;

	assign rd_x = {32'b0, rdata_s1};

	always_comb begin
		st_n       = ST_OK;
		ans_n      = '0;
		rd_n       = '0;
		total_n    = total_q;
		distinct_n = distinct_q;
		case (kind_q)
			KIND_INSERT: begin
				if (total_q == CNT_DEPTH) begin
					st_n = ST_FULL;
				end else begin
					total_n = total_q + CNT_ONE;
					if (match_q == '0)
						distinct_n = distinct_q + CNT_ONE;
				end
			end
			KIND_ERASE_FIRST: begin
				if (match_q == '0) begin
					st_n = ST_NOT_FOUND;
				end else begin
					total_n = total_q - CNT_ONE;
					ans_n   = first_pos_q + CNT_ONE;
					if (match_q == CNT_ONE)
						distinct_n = distinct_q - CNT_ONE;
				end
			end
			KIND_ERASE_ALL: begin
				if (match_q == '0) begin
					st_n = ST_NOT_FOUND;
				end else begin
					total_n    = keep_q;
					distinct_n = distinct_q - CNT_ONE;
					ans_n      = match_q;
				end
			end
			KIND_COUNT: begin
				ans_n = match_q;
				if (match_q == '0)
					st_n = ST_NOT_FOUND;
			end
			KIND_READ: begin
				if (in_range)
					rd_n = rd_x[31:0];
				else
					st_n = ST_RANGE;
			end
			default: ;
		endcase
	end

	assign ans_x  = {7'b0, ans_n};
	assign tot7_x = {7'b0, total_n};
	assign dis7_x = {7'b0, distinct_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			distinct_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				total_q    <= total_n;
				distinct_q <= distinct_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.status           <= st_n;
			res_q.answer           <= ans_x[6:0];
			res_q.read_value       <= rd_n;
			res_q.total_entries    <= tot7_x[6:0];
			res_q.distinct_entries <= dis7_x[6:0];
		end
	end

	assign done     = done_q;
	assign response = res_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_DEPTH) else $error("entry count above depth");

	a_distinct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		distinct_q <= total_q) else $error("distinct count above entry count");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> keep_q <= issue_q) else $error("compaction write ahead of scan");

endmodule
